// ----- src/slcp_pkg.sv -----
// Shared types, character codes and helpers for the SLCAN frame parser.
// No dependencies; the files that use it refer to these by scoped name.
package slcp_pkg;

  // Line length limit, counter width and frame rules
  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] LINE_LIMIT      = 7'd80;
  localparam logic [CNT_W-1:0] MIN_FRAME_CHARS = 7'd11;
  localparam logic [CNT_W-1:0] ID_LAST_POS     = 7'd8;
  localparam logic [CNT_W-1:0] LEN_POS         = 7'd9;
  localparam logic [CNT_W-1:0] DATA_POS        = 7'd10;
  localparam logic [7:0]       PF_GLOBAL_MIN   = 8'd240;

  // Character codes
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] CHAR_UA   = 8'h41;
  localparam logic [7:0] CHAR_UF   = 8'h46;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;

  // Decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // One parsed frame
  typedef struct packed {
    logic [31:0] frame_id;
    logic [17:0] group_number;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } frame_t;

  // Map an ASCII character to its hex digit value, either case
  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= CHAR_UA && c <= CHAR_UF) || (c >= CHAR_LA && c <= CHAR_LF_HEX)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

// ----- src/slcp_in_stage.sv -----
// Input register for received characters, with stall from the result side.
// No package dependencies; pure handshake logic.
module slcp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_char,
  input  logic       space,
  output logic       fire,
  output logic [7:0] cur_char
);

  logic       held;
  logic [7:0] char_q;

  // Process the held character when the result side has room
  assign fire     = held && space;
  assign in_ready = !held || space;
  assign cur_char = char_q;

  // Capture a new transaction or drain the held one
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= rx_char;
    end
  end

endmodule

// ----- src/slcp_line_parser.sv -----
// Running line state: position count, identifier, length digit and payload.
// Uses slcp_pkg for character codes, hex decode and the frame_t result type.
module slcp_line_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          cur_char,
  output logic                emit,
  output slcp_pkg::frame_t    frame
);

  logic [slcp_pkg::CNT_W-1:0] char_count, char_count_next;
  logic        start_is_t, start_is_t_next;
  logic [31:0] id_accum, id_accum_next;
  logic        id_open, id_open_next;
  logic [3:0]  len_code, len_code_next;
  logic        len_valid, len_valid_next;
  logic [63:0] data_accum, data_accum_next;
  logic [3:0]  pair_high_nibble, pair_high_nibble_next;
  logic        pair_open, pair_open_next;

  slcp_pkg::hex_t             hex;
  logic                       is_term;
  logic                       frame_ok;
  logic [slcp_pkg::CNT_W-1:0] data_off;
  logic [5:0]                 pair_idx;
  logic                       wr_en;
  logic [7:0]                 wr_val;

  assign hex      = slcp_pkg::hex_digit(cur_char);
  assign is_term  = (cur_char == slcp_pkg::CHAR_CR) || (cur_char == slcp_pkg::CHAR_LF);
  assign data_off = char_count - slcp_pkg::DATA_POS;
  assign pair_idx = data_off[slcp_pkg::CNT_W-1:1];

  // Check the finished line against the frame rules
  assign frame_ok = start_is_t && (char_count >= slcp_pkg::MIN_FRAME_CHARS) && len_valid &&
                    ({1'b0, char_count} >= (8'd10 + {3'b000, len_code, 1'b0}));

  // Assemble the result from the current line
  always_comb begin
    frame.frame_id     = id_accum;
    frame.group_number = {id_accum[25:16],
                          (id_accum[23:16] >= slcp_pkg::PF_GLOBAL_MIN) ? id_accum[15:8] : 8'h00};
    frame.data_length  = len_code;
    frame.payload      = data_accum;
  end

  // Advance the line state by one character
  always_comb begin
    char_count_next       = char_count;
    start_is_t_next       = start_is_t;
    id_accum_next         = id_accum;
    id_open_next          = id_open;
    len_code_next         = len_code;
    len_valid_next        = len_valid;
    data_accum_next       = data_accum;
    pair_high_nibble_next = pair_high_nibble;
    pair_open_next        = pair_open;
    emit                  = 1'b0;
    wr_en                 = 1'b0;
    wr_val                = 8'h00;

    if (fire) begin
      if (is_term || char_count >= slcp_pkg::LINE_LIMIT) begin
        // End of line or overflow: at end of line report a good frame, then clear
        emit                  = is_term && (char_count != '0) && frame_ok;
        if (is_term && char_count == '0) begin
          emit = 1'b0;
        end
        char_count_next       = '0;
        start_is_t_next       = 1'b0;
        id_accum_next         = 32'd0;
        id_open_next          = 1'b1;
        len_code_next         = 4'd0;
        len_valid_next        = 1'b0;
        data_accum_next       = 64'd0;
        pair_high_nibble_next = 4'd0;
        pair_open_next        = 1'b0;
      end else begin
        char_count_next = char_count + 1'b1;
        if (char_count == '0) begin
          start_is_t_next = (cur_char == slcp_pkg::CHAR_T);
        end else if (char_count <= slcp_pkg::ID_LAST_POS) begin
          if (id_open && hex.ok) begin
            id_accum_next = {id_accum[27:0], hex.val};
          end else begin
            id_open_next = 1'b0;
          end
        end else if (char_count == slcp_pkg::LEN_POS) begin
          len_valid_next = (cur_char >= slcp_pkg::CHAR_ZERO) &&
                           (cur_char <= slcp_pkg::CHAR_EIGHT);
          len_code_next  = len_valid_next ? cur_char[3:0] : 4'd0;
        end else if (len_valid && (pair_idx < {2'b00, len_code})) begin
          if (!data_off[0]) begin
            // High character of a pair
            if (hex.ok) begin
              pair_high_nibble_next = hex.val;
              pair_open_next        = 1'b1;
              wr_en                 = 1'b1;
              wr_val                = {4'h0, hex.val};
            end else begin
              pair_open_next = 1'b0;
            end
          end else begin
            // Low character of a pair
            if (pair_open && hex.ok) begin
              wr_en  = 1'b1;
              wr_val = {pair_high_nibble, hex.val};
            end
            pair_open_next = 1'b0;
          end
        end
      end
    end

    // Replace the addressed payload byte
    for (int b = 0; b < 8; b++) begin
      if (wr_en && (pair_idx[2:0] == 3'(b))) begin
        data_accum_next[8*b +: 8] = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count       <= '0;
      start_is_t       <= 1'b0;
      id_accum         <= 32'd0;
      id_open          <= 1'b1;
      len_code         <= 4'd0;
      len_valid        <= 1'b0;
      data_accum       <= 64'd0;
      pair_high_nibble <= 4'd0;
      pair_open        <= 1'b0;
    end else begin
      char_count       <= char_count_next;
      start_is_t       <= start_is_t_next;
      id_accum         <= id_accum_next;
      id_open          <= id_open_next;
      len_code         <= len_code_next;
      len_valid        <= len_valid_next;
      data_accum       <= data_accum_next;
      pair_high_nibble <= pair_high_nibble_next;
      pair_open        <= pair_open_next;
    end
  end

endmodule

// ----- src/slcp_out_stage.sv -----
// Result register holding one parsed frame until the consumer takes it.
// Uses slcp_pkg::frame_t for the held result.
module slcp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             emit,
  input  slcp_pkg::frame_t frame,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output slcp_pkg::frame_t frame_q
);

  // Room for a new result when empty or being drained this cycle
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the parsed frame
  always_ff @(posedge clk) begin
    if (emit) begin
      frame_q <= frame;
    end
  end

endmodule

// ----- src/slcan_frame_parser.sv -----
// SLCAN extended-frame parser: takes one received character per transaction
// and returns one parsed frame for each valid 'T' line. Built from slcp_pkg,
// slcp_in_stage, slcp_line_parser and slcp_out_stage.
//
// Accepts one character every clock cycle while the result side keeps up;
// a frame reaches the output after its CR or LF is accepted, by way of the
// input register, which holds the character, and the result register, which
// holds the frame. The single result register sets the stall:
// input stalls only while a character waits behind a held frame and
// out_ready is low.
module slcan_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] frame_id,
  output logic [17:0] group_number,
  output logic [3:0]  data_length,
  output logic [63:0] payload
);

  logic             space;
  logic             fire;
  logic [7:0]       cur_char;
  logic             emit;
  slcp_pkg::frame_t frame;
  slcp_pkg::frame_t frame_q;

  slcp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_char  (rx_char),
    .space    (space),
    .fire     (fire),
    .cur_char (cur_char)
  );

  slcp_line_parser u_parse (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cur_char (cur_char),
    .emit     (emit),
    .frame    (frame)
  );

  slcp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .frame     (frame),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame_q   (frame_q)
  );

  assign frame_id     = frame_q.frame_id;
  assign group_number = frame_q.group_number;
  assign data_length  = frame_q.data_length;
  assign payload      = frame_q.payload;

endmodule

// ----- src/slcp_checker.sv -----
// Port-level checks for slcan_frame_parser, attached by the bind below.
// Depends only on the top level's ports.
module slcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] frame_id,
  input logic [17:0] group_number,
  input logic [3:0]  data_length,
  input logic [63:0] payload
);

  // Held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_id) && $stable(payload))
    else $error("result changed while stalled");

  // Length digit never beyond eight
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> data_length <= 4'd8)
    else $error("data_length out of range");

  // Upper PGN bits follow the identifier
  a_pgn_high: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> group_number[17:8] == frame_id[25:16])
    else $error("group_number high bits mismatch");

  // PS appears only for global PF
  a_pgn_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_id[23:20] == 4'hF) ? (group_number[7:0] == frame_id[15:8])
                                           : (group_number[7:0] == 8'h00))
    else $error("group_number low bits mismatch");

  // Bytes past the length read zero
  a_payload_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (payload >> {data_length, 3'b000}) == 64'd0)
    else $error("payload beyond length not zero");

endmodule

bind slcan_frame_parser slcp_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_id     (frame_id),
  .group_number (group_number),
  .data_length  (data_length),
  .payload      (payload)
);
